/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/sdcw_pkg.sv */
// ---------------------------------------------------------------------------
// sdcw_pkg
// constants, register indexes and the sin^2 table generator
// ---------------------------------------------------------------------------
package sdcw_pkg;

   localparam int MAX_WIDTH_DEFAULT       = 4096;
   localparam int SINE_TABLE_BITS_DEFAULT = 10;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int SHIFT_W     = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEREO_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_AMP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS    = 3'd5;

   localparam logic [12:0] RST_IMAGE_WIDTH = 13'd4096;
   localparam logic [15:0] RST_DISTANCE    = 16'd1000;
   localparam logic [8:0]  RST_BRIGHTNESS  = 9'd256;

   localparam logic [15:0] MIN_Z_MM = 16'd10;
   localparam logic [31:0] MIN_ZQ   = 32'd655360;  // 10 mm in q16
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // sin^2(pi/2 * k / 2^bits) in q1.16, taylor series in q2.30
   function automatic logic [16:0] sine_entry(input int unsigned k, input int bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned sq;
      x    = (PI_Q30 * longint'(k)) >> (bits + 1);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
         term = (term * x2) >> 30;
         case (n)
            1: begin term = term / 6; end
            2: begin term = term / 20; end
            3: begin term = term / 42; end
            4: begin term = term / 72; end
            5: begin term = term / 110; end
            6: begin term = term / 156; end
            default: begin term = term / 210; end
         endcase
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      sq = (sum * sum + (64'd1 << 43)) >> 44;
      return (sq > 64'd65536) ? 17'd65536 : 17'(sq);
   endfunction

endpackage

/* src/stereo_disparity_column_warp.sv */
// ---------------------------------------------------------------------------
// stereo_disparity_column_warp
// Keeps one row of RGBA8 pixels and returns per-column stereo pairs. A write
// transaction (tuser 0) stores a pixel; a read transaction (tuser 1) returns
// the left pixel from column - shift and the right from column + shift, with
// the shift derived from the depth curve and brightness applied to RGB.
// The block takes one transaction per clock unless rsp_tready back-pressure
// fills the pipeline; a read passes the restoring dividers for the table
// index and for the shift, one quotient bit per stage, then the line store.
// Bubbles collapse, so input keeps flowing while a result waits, until every
// stage is full. The line store has no clearing pass after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_disparity_column_warp #(
   parameter int MAX_WIDTH       = sdcw_pkg::MAX_WIDTH_DEFAULT,
   parameter int SINE_TABLE_BITS = sdcw_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [47:0]                        req_tdata,   // column[11:0], pixel_rgba[43:12]
   input  logic                               req_tuser,   // operation
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [79:0]                        rsp_tdata,   // left[31:0], right[63:32], shift[75:64]
   input  logic                               csr_we,
   input  logic [sdcw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sdcw_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW       = $clog2(MAX_WIDTH);
   localparam int STEPS    = 1 << SINE_TABLE_BITS;
   localparam int QIW      = SINE_TABLE_BITS + 1;
   localparam int RIW      = SINE_TABLE_BITS + 14;
   localparam int SW       = sdcw_pkg::SHIFT_W;
   localparam int ST_IN    = 0;
   localparam int ST_IDX   = 1;
   localparam int ST_ROM   = ST_IDX + QIW;
   localparam int ST_RED   = ST_ROM + 1;
   localparam int ST_ZQ    = ST_RED + 1;
   localparam int ST_PROD  = ST_ZQ + 1;
   localparam int ST_SUM   = ST_PROD + 1;
   localparam int ST_SAT   = ST_SUM + 1;
   localparam int ST_QS    = ST_SAT + 1;
   localparam int ST_SHIFT = ST_QS + SW;
   localparam int ST_ADDR  = ST_SHIFT + 1;
   localparam int ST_MEM   = ST_ADDR + 1;
   localparam int ST_OUT   = ST_MEM + 1;
   localparam int NS       = ST_OUT + 1;

   typedef logic [16:0] rom_type [STEPS+1];

   typedef struct packed {
      logic           op;
      logic [11:0]    col;
      logic [31:0]    pix;
      logic [11:0]    x;
      logic           zero;
      logic [RIW-1:0] rem_i;
      logic [QIW-1:0] q_i;
      logic [16:0]    sin2;
      logic [31:0]    red;
      logic [31:0]    zq;
      logic [31:0]    num;
      logic [55:0]    prod;
      logic [56:0]    rem_s;
      logic           sat;
      logic [SW-1:0]  q_s;
      logic [SW-1:0]  shift;
      logic [12:0]    lsrc;
      logic [12:0]    rsrc;
      logic [31:0]    lpix;
      logic [31:0]    rpix;
   } item_type;

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k <= STEPS; k++) begin
         r[k] = sdcw_pkg::sine_entry(k, SINE_TABLE_BITS);
      end
      return r;
   endfunction

   localparam rom_type SIN2_ROM = build_rom();

   function automatic logic [31:0] shade(input logic [31:0] p, input logic [8:0] b);
      logic [15:0] pr;
      logic [15:0] pg;
      logic [15:0] pb;
      pr = 16'(p[7:0]) * 16'(b[7:0]);
      pg = 16'(p[15:8]) * 16'(b[7:0]);
      pb = 16'(p[23:16]) * 16'(b[7:0]);
      return b[8] ? p : {p[31:24], pb[15:8], pg[15:8], pr[15:8]};
   endfunction

   // configuration
   logic        stereo_ff;
   logic [12:0] width_ff;
   logic [15:0] dist_ff;
   logic [14:0] amp_ff;
   logic [23:0] scale_ff;
   logic [8:0]  bright_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff <= 1'b0;
         width_ff  <= sdcw_pkg::RST_IMAGE_WIDTH;
         dist_ff   <= sdcw_pkg::RST_DISTANCE;
         amp_ff    <= '0;
         scale_ff  <= '0;
         bright_ff <= sdcw_pkg::RST_BRIGHTNESS;
      end else if (csr_we) begin
         case (csr_index)
            sdcw_pkg::CSR_STEREO_ENABLE: begin stereo_ff <= csr_wdata[0]; end
            sdcw_pkg::CSR_IMAGE_WIDTH:   begin width_ff  <= csr_wdata[12:0]; end
            sdcw_pkg::CSR_DISTANCE:      begin dist_ff   <= csr_wdata[15:0]; end
            sdcw_pkg::CSR_DEPTH_AMP:     begin amp_ff    <= csr_wdata[14:0]; end
            sdcw_pkg::CSR_SCALE:         begin scale_ff  <= csr_wdata; end
            sdcw_pkg::CSR_BRIGHTNESS:    begin bright_ff <= csr_wdata[8:0]; end
            default: begin end
         endcase
      end
   end

   logic [12:0]   w;
   logic [12:0]   wm1;
   logic [SW-1:0] cap;

   assign w   = (32'(width_ff) > MAX_WIDTH) ? 13'(MAX_WIDTH) : width_ff;
   assign wm1 = w - 13'd1;
   assign cap = (wm1 > 13'd4095) ? 12'd4095 : wm1[11:0];

   // pipeline
   item_type       item_ff [NS];
   item_type       item_in [NS];
   logic [NS-1:0]  vld_ff;
   logic [NS-1:0]  vld_in;
   logic [NS-1:0]  en;
   logic [31:0]    rd_a;
   logic [31:0]    rd_b;

   for (genvar i = 0; i < NS; i++) begin : g_stage
      // a stage loads when empty or when it drains into the next one
      if (i == NS - 1) begin : g_last
         assign en[i] = !vld_ff[i] || rsp_tready;
      end else begin : g_mid
         assign en[i] = !vld_ff[i] || en[i+1];
      end

      if (i == ST_IN) begin : g_in
         assign vld_in[i] = req_tvalid;
         always_comb begin
            logic [12:0] t;
            logic [12:0] span;
            item_in[i]      = '0;
            item_in[i].op   = req_tuser;
            item_in[i].col  = req_tdata[11:0];
            item_in[i].pix  = req_tdata[43:12];
            item_in[i].x    = (13'(req_tdata[11:0]) < w) ? req_tdata[11:0] : wm1[11:0];
            t               = {item_in[i].x, 1'b1};
            span            = (t >= w) ? t - w : w - t;
            item_in[i].zero = (w == 13'd0) || (stereo_ff && dist_ff < sdcw_pkg::MIN_Z_MM);
            item_in[i].rem_i = (RIW'(span) << SINE_TABLE_BITS) + RIW'(w >> 1);
         end
      end else if (i == ST_OUT) begin : g_out
         assign vld_in[i] = vld_ff[i-1] && item_ff[i-1].op;
         always_comb begin
            item_in[i]       = item_ff[i-1];
            item_in[i].lpix  = item_ff[i-1].zero ? 32'd0 : shade(rd_a, bright_ff);
            item_in[i].rpix  = item_ff[i-1].zero ? 32'd0 : shade(rd_b, bright_ff);
            item_in[i].shift = item_ff[i-1].zero ? '0 : item_ff[i-1].shift;
         end
      end else begin : g_work
         assign vld_in[i] = vld_ff[i-1];
         if (i >= ST_IDX && i < ST_ROM) begin : g_idx
            localparam int K = ST_ROM - 1 - i;
            always_comb begin
               logic [RIW-1:0] dv;
               item_in[i] = item_ff[i-1];
               dv = RIW'(w) << K;
               if (item_ff[i-1].rem_i >= dv) begin
                  item_in[i].rem_i  = item_ff[i-1].rem_i - dv;
                  item_in[i].q_i[K] = 1'b1;
               end
            end
         end else if (i == ST_ROM) begin : g_rom
            always_comb begin
               logic [QIW-1:0] idx;
               item_in[i] = item_ff[i-1];
               idx = (item_ff[i-1].q_i > QIW'(STEPS)) ? QIW'(STEPS) : item_ff[i-1].q_i;
               item_in[i].sin2 = SIN2_ROM[idx];
            end
         end else if (i == ST_RED) begin : g_red
            always_comb begin
               item_in[i]     = item_ff[i-1];
               item_in[i].red = 32'(amp_ff) * 32'(item_ff[i-1].sin2);
            end
         end else if (i == ST_ZQ) begin : g_zq
            always_comb begin
               logic [31:0] dq;
               logic [31:0] z;
               item_in[i] = item_ff[i-1];
               dq = {dist_ff, 16'd0};
               z  = (dq > item_ff[i-1].red) ? dq - item_ff[i-1].red : 32'd0;
               if (z < sdcw_pkg::MIN_ZQ) begin
                  z = sdcw_pkg::MIN_ZQ;
               end
               item_in[i].zq  = z;
               item_in[i].num = dq - z;
            end
         end else if (i == ST_PROD) begin : g_prod
            always_comb begin
               item_in[i]      = item_ff[i-1];
               item_in[i].prod = 56'(scale_ff) * 56'(item_ff[i-1].num);
            end
         end else if (i == ST_SUM) begin : g_sum
            // numerator plus half the q16*256 denominator for rounding
            always_comb begin
               item_in[i]       = item_ff[i-1];
               item_in[i].rem_s = 57'(item_ff[i-1].prod) + (57'(item_ff[i-1].zq) << 7);
            end
         end else if (i == ST_SAT) begin : g_sat
            always_comb begin
               item_in[i]     = item_ff[i-1];
               item_in[i].sat = item_ff[i-1].rem_s >= (57'(item_ff[i-1].zq) << (8 + SW));
               item_in[i].q_s = '0;
            end
         end else if (i >= ST_QS && i < ST_SHIFT) begin : g_qs
            localparam int K = ST_SHIFT - 1 - i;
            always_comb begin
               logic [56:0] dv;
               item_in[i] = item_ff[i-1];
               dv = 57'(item_ff[i-1].zq) << (8 + K);
               if (!item_ff[i-1].sat && item_ff[i-1].rem_s >= dv) begin
                  item_in[i].rem_s  = item_ff[i-1].rem_s - dv;
                  item_in[i].q_s[K] = 1'b1;
               end
            end
         end else if (i == ST_SHIFT) begin : g_shift
            always_comb begin
               logic [SW-1:0] sh;
               item_in[i] = item_ff[i-1];
               sh = item_ff[i-1].sat ? '1 : item_ff[i-1].q_s;
               item_in[i].shift = (sh > cap) ? cap : sh;
            end
         end else if (i == ST_ADDR) begin : g_addr
            always_comb begin
               logic [12:0] sum;
               item_in[i] = item_ff[i-1];
               sum = 13'(item_ff[i-1].x) + 13'(item_ff[i-1].shift);
               if (!stereo_ff) begin
                  item_in[i].lsrc  = 13'(item_ff[i-1].x);
                  item_in[i].rsrc  = 13'(item_ff[i-1].x);
                  item_in[i].shift = '0;
               end else begin
                  item_in[i].lsrc = (item_ff[i-1].x >= item_ff[i-1].shift) ?
                                    13'(item_ff[i-1].x - item_ff[i-1].shift) : 13'd0;
                  item_in[i].rsrc = (sum > wm1) ? wm1 : sum;
               end
            end
         end else begin : g_pass
            // memory stage, data comes back from the line store
            always_comb begin
               item_in[i] = item_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (vld_ff & ~en) | (vld_in & en);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (en[i]) begin
            item_ff[i] <= item_in[i];
         end
      end
   end

   // writes land in program order with the reads, at the memory stage
   logic wr_en;

   assign wr_en = en[ST_MEM] && vld_ff[ST_ADDR] && !item_ff[ST_ADDR].op &&
                  (32'(item_ff[ST_ADDR].col) < MAX_WIDTH);

   sdcw_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (AW'(item_ff[ST_ADDR].col)),
      .wr_data   (item_ff[ST_ADDR].pix),
      .rd_en     (en[ST_MEM]),
      .rd_addr_a (AW'(item_ff[ST_ADDR].lsrc)),
      .rd_addr_b (AW'(item_ff[ST_ADDR].rsrc)),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign req_tready = en[ST_IN];
   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = {4'd0, item_ff[ST_OUT].shift, item_ff[ST_OUT].rpix, item_ff[ST_OUT].lpix};

   logic mono_ok;
   logic shift_ok;

   assign mono_ok  = (rsp_tdata[75:64] == 12'd0) && (rsp_tdata[31:0] == rsp_tdata[63:32]);
   assign shift_ok = (rsp_tdata[75:64] == 12'd0) || (13'(rsp_tdata[75:64]) < w);

   `ASSERT_IMPLY(a_out_is_read, clock, reset, vld_ff[ST_OUT], item_ff[ST_OUT].op)
   `ASSERT_IMPLY(a_mono_pair, clock, reset, rsp_tvalid && !stereo_ff, mono_ok)
   `ASSERT_IMPLY(a_shift_in_row, clock, reset, rsp_tvalid, shift_ok)
   `ASSERT_NEXT(a_accept_lands, clock, reset, req_tvalid && req_tready, vld_ff[ST_IN])

endmodule

/* src/sdcw_line_store.sv */
// ---------------------------------------------------------------------------
// sdcw_line_store
// one-row pixel memory, one write port and two registered read ports
// ---------------------------------------------------------------------------
module sdcw_line_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [31:0]   rd_data_a,
   output logic [31:0]   rd_data_b
);

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo disparity column warp. Random and
// directed pixel writes and stereo reads are driven through the request
// stream under several configurations and back-pressure mixes. Every read
// result is compared with an in-bench prediction of the warped pair.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_MAX     = 4096;
   localparam int TABLE_STEPS = 1024;
   localparam int LATENCY     = 34;
   localparam int CYCLE_LIMIT = 1500000;

   typedef enum logic {OP_WRITE = 1'b0, OP_READ = 1'b1} op_type;

   typedef struct packed {
      op_type      op;
      logic [11:0] column;
      logic [31:0] pixel;
   } pixel_req_type;

   typedef struct packed {
      logic [31:0] left;
      logic [31:0] right;
      logic [11:0] shift;
   } pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // column[11:0], pixel_rgba[43:12]
   logic        req_tuser = 1'b0; // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // left[31:0], right[63:32], shift[75:64]
   logic        csr_we = 1'b0;
   logic [sdcw_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sdcw_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   stereo_disparity_column_warp uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [31:0] row_copy [ROW_MAX];
   bit          row_written [ROW_MAX];
   logic [16:0] sin2_lut [TABLE_STEPS+1];
   bit          p_stereo;
   int unsigned p_width, p_dist, p_amp, p_scale, p_bright;

   pixel_req_type pending_reqs[$];
   pair_type      expected_pairs[$];
   int          send_idle_pct, recv_stall_pct;
   int          hold_off_cycles;
   int          errors, reads_checked, writes_sent, items_sent;
   longint      cycle_count;
   bit          req_taken;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $time);
      errors++;
   endtask

   function automatic logic [16:0] sin2_value(input int unsigned k);
      longint unsigned x, x2, term, acc, sq;
      x = (64'd3373259426 * k) / (2 * TABLE_STEPS);
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n % 2) acc = acc - term;
         else acc = acc + term;
      end
      sq = (acc * acc + (64'd1 << 43)) >> 44;
      return sq > 65536 ? 17'd65536 : 17'(sq);
   endfunction

   function automatic logic [31:0] dim(input logic [31:0] p);
      logic [31:0] q;
      if (p_bright >= 256) return p;
      q = p;
      for (int b = 0; b < 3; b++) q[8*b +: 8] = (p[8*b +: 8] * p_bright) >> 8;
      return q;
   endfunction

   function automatic pair_type warp_pair(input int unsigned col);
      pair_type r;
      int unsigned w, x, span, idx, cap, shift;
      longint unsigned dq, red, zq, num, den, sh;
      r = '0;
      w = p_width > ROW_MAX ? ROW_MAX : p_width;
      if (w == 0) return r;
      x = col < w ? col : w - 1;
      if (!p_stereo) begin
         r.left = dim(row_copy[x]);
         r.right = r.left;
         return r;
      end
      if (p_dist < 10) return r;
      span = (2*x + 1 >= w) ? 2*x + 1 - w : w - 2*x - 1;
      idx = (longint'(span) * TABLE_STEPS + w / 2) / w;
      if (idx > TABLE_STEPS) idx = TABLE_STEPS;
      dq = longint'(p_dist) << 16;
      red = longint'(p_amp) * sin2_lut[idx];
      zq = dq > red ? dq - red : 0;
      if (zq < (64'd10 << 16)) zq = 64'd10 << 16;
      num = dq - zq;
      den = zq * 256;
      sh = (longint'(p_scale) * num + den / 2) / den;
      cap = w - 1 > 4095 ? 4095 : w - 1;
      shift = sh > cap ? cap : sh;
      r.left = dim(row_copy[x >= shift ? x - shift : 0]);
      r.right = dim(row_copy[x + shift > w - 1 ? w - 1 : x + shift]);
      r.shift = 12'(shift);
      return r;
   endfunction

   // driver, holds an offered transaction until it is taken
   always @(negedge clock) begin
      if (!reset) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_reqs[0].op;
            req_tdata <= {4'b0, pending_reqs[0].pixel, pending_reqs[0].column};
         end else if (req_taken || !req_tvalid) begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with a counted hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // predictor fed at acceptance, checker at rising edge
   always @(posedge clock) begin
      pair_type got, want;
      cycle_count++;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         void'(pending_reqs.pop_front());
         if (req_tuser == OP_WRITE) begin
            row_copy[req_tdata[11:0]] = req_tdata[43:12];
            row_written[req_tdata[11:0]] = 1;
         end else begin
            expected_pairs.push_back(warp_pair(req_tdata[11:0]));
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[75:64]};
         if (expected_pairs.size() == 0) begin
            report("unexpected result", rsp_tdata[63:0], 0);
         end else begin
            want = expected_pairs.pop_front();
            reads_checked++;
            if (got.left !== want.left) report("left_pixel", got.left, want.left);
            if (got.right !== want.right) report("right_pixel", got.right, want.right);
            if (got.shift !== want.shift) report("shift_pixels", got.shift, want.shift);
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [sdcw_pkg::CSR_INDEX_W-1:0] idx,
                            input int unsigned val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= sdcw_pkg::CSR_DATA_W'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         sdcw_pkg::CSR_STEREO_ENABLE: p_stereo = val[0];
         sdcw_pkg::CSR_IMAGE_WIDTH:   p_width = val & 13'h1fff;
         sdcw_pkg::CSR_DISTANCE:      p_dist = val & 16'hffff;
         sdcw_pkg::CSR_DEPTH_AMP:     p_amp = val & 15'h7fff;
         sdcw_pkg::CSR_SCALE:         p_scale = val & 24'hffffff;
         sdcw_pkg::CSR_BRIGHTNESS:    p_bright = val & 9'h1ff;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_pairs.size() > 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic configure(input bit st, input int unsigned w, input int unsigned d,
                            input int unsigned a, input int unsigned s, input int unsigned b);
      drain();
      write_reg(sdcw_pkg::CSR_STEREO_ENABLE, st);
      write_reg(sdcw_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(sdcw_pkg::CSR_DISTANCE, d);
      write_reg(sdcw_pkg::CSR_DEPTH_AMP, a);
      write_reg(sdcw_pkg::CSR_SCALE, s);
      write_reg(sdcw_pkg::CSR_BRIGHTNESS, b);
   endtask

   task automatic push_item(input op_type op, input int unsigned col, input logic [31:0] px);
      pixel_req_type t;
      t.op = op;
      t.column = 12'(col);
      t.pixel = px;
      pending_reqs.push_back(t);
      items_sent++;
      if (op == OP_WRITE) begin
         writes_sent++;
         row_written[col] = 1;
      end
   endtask

   // a read is preceded by writes to whichever of its source columns are
   // still empty under the current settings
   task automatic read_at(input int unsigned col);
      int unsigned w, x, lo, hi;
      pair_type r;
      w = p_width > ROW_MAX ? ROW_MAX : p_width;
      if (w != 0) begin
         x = col < w ? col : w - 1;
         lo = x;
         hi = x;
         if (p_stereo) begin
            r = warp_pair(col);
            lo = x >= r.shift ? x - r.shift : 0;
            hi = x + r.shift > w - 1 ? w - 1 : x + r.shift;
         end
         if (!p_stereo || p_dist >= 10) begin
            if (!row_written[lo]) push_item(OP_WRITE, lo, $urandom);
            if (!row_written[hi]) push_item(OP_WRITE, hi, $urandom);
         end
      end
      push_item(OP_READ, col, $urandom);
   endtask

   task automatic random_items(input int n, input int unsigned wlim);
      int unsigned c;
      int start;
      start = items_sent;
      while (items_sent - start < n) begin
         c = $urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(wlim);
         if ($urandom_range(99) < 35) push_item(OP_WRITE, c, $urandom);
         else read_at(c);
      end
   endtask

   initial begin
      p_stereo = 0; p_width = 4096; p_dist = 1000; p_amp = 0; p_scale = 0; p_bright = 256;
      for (int k = 0; k <= TABLE_STEPS; k++) sin2_lut[k] = sin2_value(k);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: mono reads at the row ends, then field extremes
      for (int c = 0; c < ROW_MAX; c += 1) row_written[c] = 0;
      push_item(OP_WRITE, 0, 32'h00000000);
      push_item(OP_WRITE, 4095, 32'hffffffff);
      push_item(OP_READ, 0, 32'hffffffff);
      push_item(OP_READ, 4095, 32'h0);
      drain();
      configure(0, 16, 1000, 0, 0, 255);
      read_at(4095);  // column beyond width is clamped
      read_at(7);
      configure(1, 0, 1000, 100, 256, 256);
      read_at(5);     // zero width
      configure(1, 8191, 5, 32767, 16777215, 0);
      read_at(100);   // distance under the minimum, oversized width
      configure(1, 4096, 65535, 32767, 16777215, 128);
      read_at(0);
      read_at(2047);
      read_at(4095);
      configure(1, 1, 10, 0, 0, 256);
      read_at(0);
      configure(1, 640, 200, 190, 1200, 200);
      read_at(0);
      read_at(320);
      read_at(639);

      // random phases under different idling and settings
      configure(1, 1024, 500, 300, 3000, 256);
      random_items(200, 1100);
      configure(1, 4096, 800, 700, 40000, 90);
      send_idle_pct = 78;
      random_items(200, 4095);
      configure(0, 300, 0, 0, 0, 0);
      send_idle_pct = 0;
      recv_stall_pct = 78;
      random_items(200, 400);
      configure(1, 37, 65535, 32767, 16777215, 1);
      send_idle_pct = 18;
      recv_stall_pct = 18;
      random_items(200, 50);
      configure(1, 2000, 1500, 1490, 900000, 256);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 300;
      random_items(220, 2100);
      drain();

      $display("checked %0d read results out of %0d transactions (%0d writes)",
               reads_checked, items_sent, writes_sent);
      $display("covered 12 settings, idle and stall mixes and one long receiver hold-off");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
